// ===== hdl/wsfd_pkg.sv =====
// wsfd_pkg: shared types and constants for the frame deframer.
// Used by wsfd_front, wsfd_queue, wsfd_back and websocket_frame_deframer.
package wsfd_pkg;

   localparam int QUEUE_DEPTH = 4;

   localparam logic [3:0] OP_TEXT   = 4'h1;
   localparam logic [3:0] OP_BINARY = 4'h2;
   localparam logic [3:0] OP_CLOSE  = 4'h8;
   localparam logic [3:0] OP_PING   = 4'h9;
   localparam logic [3:0] OP_PONG   = 4'hA;

   localparam logic [6:0] LEN7_EXT16 = 7'd126;
   localparam logic [6:0] LEN7_EXT64 = 7'd127;

   // one classified beat handed from the parser to the unmask stage
   typedef struct packed {
      logic [7:0] data;
      logic [7:0] key;
      logic       has_data;
      logic       last;
      logic [3:0] opcode;
   } entry_type;

endpackage

// ===== hdl/websocket_frame_deframer.sv =====
// websocket_frame_deframer: top level of the frame decoder.
// Depends on wsfd_pkg, wsfd_front, wsfd_queue and wsfd_back.
//
//   channel | ports   | beat
//   --------+---------+-----------------------------------------------------
//   input   | req_*   | one received byte
//   result  | rsp_*   | one unmasked payload byte or a frame end marker
//
// One byte accepted per cycle while the queue is not full; each result is registered.
// Header and key bytes give no result; a zero-length frame gives one end marker.
// A 4-beat queue and the output register let the parser run while the result
// side stalls; req_tready drops only when that queue is full.
// Reset (synchronous, high) returns to the first header byte with the link open.
module websocket_frame_deframer #(
   parameter int LENGTH_BITS = 64
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_tvalid,
   output logic       req_tready,
   input  logic [7:0] req_tdata,   // [7:0] rx_byte
   output logic       rsp_tvalid,
   input  logic       rsp_tready,
   output logic [7:0] rsp_tdata,   // [7:0] payload_byte
   output logic       rsp_tlast,   // frame_end
   output logic [6:0] rsp_tuser    // [0] payload_valid, [4:1] frame_opcode,
                                   // [5] close_received, [6] unknown_opcode
);

   logic                push_valid;
   wsfd_pkg::entry_type push_entry;
   logic                queue_full;
   logic                pop_valid;
   wsfd_pkg::entry_type pop_entry;
   logic                pop_ready;

   wsfd_front #(
      .LENGTH_BITS(LENGTH_BITS)
   ) u_front (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .push_valid (push_valid),
      .push_entry (push_entry),
      .queue_full (queue_full)
   );

   wsfd_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_entry (push_entry),
      .full       (queue_full),
      .pop_valid  (pop_valid),
      .pop_entry  (pop_entry),
      .pop_ready  (pop_ready)
   );

   wsfd_back u_back (
      .clock      (clock),
      .reset      (reset),
      .pop_valid  (pop_valid),
      .pop_entry  (pop_entry),
      .pop_ready  (pop_ready),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast),
      .rsp_tuser  (rsp_tuser)
   );

endmodule

// ===== hdl/wsfd_front.sv =====
// wsfd_front: header parser; takes received bytes, tracks length and mask key,
// pushes one classified beat per result. Depends on wsfd_pkg.
module wsfd_front #(
   parameter int LENGTH_BITS = 64
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_tvalid,
   output logic                req_tready,
   input  logic [7:0]          req_tdata,
   output logic                push_valid,
   output wsfd_pkg::entry_type push_entry,
   input  logic                queue_full
);

   typedef enum logic [5:0] {
      PH_HDR0    = 6'b000001,
      PH_HDR1    = 6'b000010,
      PH_EXT16   = 6'b000100,
      PH_EXT64   = 6'b001000,
      PH_MASK    = 6'b010000,
      PH_PAYLOAD = 6'b100000
   } phase_type;

   localparam logic [LENGTH_BITS-1:0] LenZero = '0;
   localparam logic [LENGTH_BITS-1:0] LenOne  = {{(LENGTH_BITS-1){1'b0}}, 1'b1};

   phase_type              phase_ff, phase_in;
   logic [3:0]             opcode_ff, opcode_in;
   logic                   mask_ff, mask_in;
   logic [3:0]             count_ff, count_in;
   logic [LENGTH_BITS-1:0] remain_ff, remain_in;
   logic [31:0]            key_ff, key_in;
   logic [1:0]             index_ff, index_in;
   logic                   open_ff, open_in;

   logic                   accept;
   logic                   len_done;
   logic                   start;
   logic                   emit_last;
   logic [6:0]             len7;
   logic [7:0]             key_byte;

   assign req_tready = !open_ff || !queue_full;
   assign accept     = req_tvalid && req_tready && open_ff;
   assign len7       = req_tdata[6:0];

   always_comb begin
      case (index_ff)
         2'd0:    key_byte = key_ff[31:24];
         2'd1:    key_byte = key_ff[23:16];
         2'd2:    key_byte = key_ff[15:8];
         default: key_byte = key_ff[7:0];
      endcase
   end

   always_comb begin
      phase_in   = phase_ff;
      opcode_in  = opcode_ff;
      mask_in    = mask_ff;
      count_in   = count_ff;
      remain_in  = remain_ff;
      key_in     = key_ff;
      index_in   = index_ff;
      open_in    = open_ff;
      len_done   = 1'b0;
      start      = 1'b0;
      emit_last  = 1'b0;
      push_valid = 1'b0;
      push_entry = '{data: req_tdata, key: key_byte, has_data: 1'b0,
                     last: 1'b0, opcode: opcode_ff};
      if (accept) begin
         case (phase_ff)
            PH_HDR1: begin
               mask_in   = req_tdata[7];
               count_in  = '0;
               remain_in = LenZero;
               if (len7 == wsfd_pkg::LEN7_EXT16) begin
                  phase_in = PH_EXT16;
               end else if (len7 == wsfd_pkg::LEN7_EXT64) begin
                  phase_in = PH_EXT64;
               end else begin
                  remain_in = {{(LENGTH_BITS-7){1'b0}}, len7};
                  len_done  = 1'b1;
               end
            end
            PH_EXT16, PH_EXT64: begin
               remain_in = {remain_ff[LENGTH_BITS-9:0], req_tdata};
               count_in  = count_ff + 4'd1;
               if (count_in == ((phase_ff == PH_EXT16) ? 4'd2 : 4'd8)) begin
                  len_done = 1'b1;
               end
            end
            PH_MASK: begin
               key_in   = {key_ff[23:0], req_tdata};
               count_in = count_ff + 4'd1;
               if (count_in == 4'd4) begin
                  count_in = '0;
                  start    = 1'b1;
               end
            end
            PH_PAYLOAD: begin
               push_valid          = 1'b1;
               push_entry.has_data = 1'b1;
               push_entry.last     = (remain_ff == LenOne);
               emit_last           = push_entry.last;
               index_in            = index_ff + 2'd1;
               remain_in           = remain_ff - LenOne;
            end
            default: begin
               opcode_in = req_tdata[3:0];
               phase_in  = PH_HDR1;
            end
         endcase
         if (len_done) begin
            count_in = '0;
            if (mask_in) begin
               phase_in = PH_MASK;
            end else begin
               key_in = '0;
               start  = 1'b1;
            end
         end
         if (start) begin
            index_in = '0;
            if (remain_in == LenZero) begin
               push_valid      = 1'b1;
               push_entry.last = 1'b1;
               emit_last       = 1'b1;
            end else begin
               phase_in = PH_PAYLOAD;
            end
         end
         if (emit_last) begin
            phase_in = PH_HDR0;
            if (opcode_ff == wsfd_pkg::OP_CLOSE) begin
               open_in = 1'b0;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff  <= PH_HDR0;
         opcode_ff <= '0;
         mask_ff   <= 1'b0;
         count_ff  <= '0;
         remain_ff <= LenZero;
         key_ff    <= '0;
         index_ff  <= '0;
         open_ff   <= 1'b1;
      end else begin
         phase_ff  <= phase_in;
         opcode_ff <= opcode_in;
         mask_ff   <= mask_in;
         count_ff  <= count_in;
         remain_ff <= remain_in;
         key_ff    <= key_in;
         index_ff  <= index_in;
         open_ff   <= open_in;
      end
   end

`ifndef SYNTH
   assert property (@(posedge clock) disable iff (reset)
      !open_ff |-> !push_valid)
      else $error("beat pushed after link closed");
   assert property (@(posedge clock) disable iff (reset)
      phase_ff == PH_PAYLOAD |-> remain_ff != LenZero)
      else $error("payload phase with no bytes left");
   assert property (@(posedge clock) disable iff (reset)
      $fell(open_ff) |-> $past(opcode_ff) == wsfd_pkg::OP_CLOSE && $past(push_valid))
      else $error("link closed without a close frame end");
`endif

endmodule

// ===== hdl/wsfd_queue.sv =====
// wsfd_queue: short FIFO of classified beats between parser and unmask stage.
// Depends on wsfd_pkg.
module wsfd_queue (
   input  logic                clock,
   input  logic                reset,
   input  logic                push_valid,
   input  wsfd_pkg::entry_type push_entry,
   output logic                full,
   output logic                pop_valid,
   output wsfd_pkg::entry_type pop_entry,
   input  logic                pop_ready
);

   localparam int PtrBits   = $clog2(wsfd_pkg::QUEUE_DEPTH);
   localparam int CountBits = $clog2(wsfd_pkg::QUEUE_DEPTH + 1);
   localparam logic [CountBits-1:0] CountFull = CountBits'(wsfd_pkg::QUEUE_DEPTH);

   wsfd_pkg::entry_type slot_ff [wsfd_pkg::QUEUE_DEPTH];
   logic [PtrBits-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [PtrBits-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [CountBits-1:0] count_ff, count_in;
   logic                 do_push, do_pop;

   assign full      = (count_ff == CountFull);
   assign pop_valid = (count_ff != '0);
   assign pop_entry = slot_ff[rd_ptr_ff];
   assign do_push   = push_valid && !full;
   assign do_pop    = pop_valid && pop_ready;

   always_comb begin
      wr_ptr_in = do_push ? wr_ptr_ff + PtrBits'(1) : wr_ptr_ff;
      rd_ptr_in = do_pop ? rd_ptr_ff + PtrBits'(1) : rd_ptr_ff;
      count_in  = count_ff;
      if (do_push && !do_pop) begin
         count_in = count_ff + CountBits'(1);
      end else if (do_pop && !do_push) begin
         count_in = count_ff - CountBits'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         slot_ff[wr_ptr_ff] <= push_entry;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

`ifndef SYNTH
   assert property (@(posedge clock) disable iff (reset)
      full |-> !push_valid)
      else $error("push into full queue");
`endif

endmodule

// ===== hdl/wsfd_back.sv =====
// wsfd_back: unmasks payload beats, flags frame ends and holds the result register.
// Depends on wsfd_pkg.
module wsfd_back (
   input  logic                clock,
   input  logic                reset,
   input  logic                pop_valid,
   input  wsfd_pkg::entry_type pop_entry,
   output logic                pop_ready,
   output logic                rsp_tvalid,
   input  logic                rsp_tready,
   output logic [7:0]          rsp_tdata,
   output logic                rsp_tlast,
   output logic [6:0]          rsp_tuser
);

   logic       valid_ff, valid_in;
   logic [7:0] data_ff, data_in;
   logic       last_ff, last_in;
   logic [6:0] user_ff, user_in;
   logic       known;
   logic       take;

   assign pop_ready = !valid_ff || rsp_tready;
   assign take      = pop_valid && pop_ready;

   always_comb begin
      case (pop_entry.opcode)
         wsfd_pkg::OP_TEXT, wsfd_pkg::OP_BINARY, wsfd_pkg::OP_CLOSE,
         wsfd_pkg::OP_PING, wsfd_pkg::OP_PONG: known = 1'b1;
         default:                              known = 1'b0;
      endcase
   end

   always_comb begin
      valid_in = valid_ff;
      if (pop_ready) begin
         valid_in = pop_valid;
      end
      data_in = pop_entry.has_data ? (pop_entry.data ^ pop_entry.key) : 8'h00;
      last_in = pop_entry.last;
      user_in = {pop_entry.last && !known,
                 pop_entry.last && (pop_entry.opcode == wsfd_pkg::OP_CLOSE),
                 pop_entry.opcode,
                 pop_entry.has_data};
   end

   always_ff @(posedge clock) begin
      if (take) begin
         data_ff <= data_in;
         last_ff <= last_in;
         user_ff <= user_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   assign rsp_tvalid = valid_ff;
   assign rsp_tdata  = data_ff;
   assign rsp_tlast  = last_ff;
   assign rsp_tuser  = user_ff;

`ifndef SYNTH
   assert property (@(posedge clock) disable iff (reset)
      valid_ff && !last_ff |-> !user_ff[5] && !user_ff[6])
      else $error("end flags on a beat that is not a frame end");
`endif

endmodule
